// ===== rtl/sis_pkg.sv =====
// Package for the 2D segment intersection block: widths, payload types and
// the state that travels through the divider chain. No dependencies.
package sis_pkg;

	localparam int CW = 32;          // coordinate width
	localparam int FB = 16;          // fraction bits
	localparam int DW = CW + 1;      // exact coordinate difference
	localparam int PW = 2 * DW;      // exact product of two differences
	localparam int SW = PW + 1;      // determinant and numerators
	localparam int NW = SW + FB;     // scaled numerator of t
	localparam int QW = CW;          // quotient bits produced by the chain
	localparam int MW = DW + CW;     // point product width

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] det_t;
	typedef logic [SW-1:0] mag_t;
	typedef logic [QW-1:0] quo_t;

	// One input item as a struct.
	typedef struct packed {
		coord_t a1x, a1y, a1z;
		coord_t a2x, a2y, a2z;
		coord_t b1x, b1y;
		coord_t b2x, b2y;
	} in_item_t;

	// Values needed for the point once t is known.
	typedef struct packed {
		coord_t a1x, a1y, a1z;
		diff_t dx, dy, dz;
		logic hit;
		logic par;
		logic neg;
	} pt_carry_t;

	// State handed from one divider cell to the next.
	typedef struct packed {
		mag_t rem;
		mag_t dvs;
		quo_t lo;
		quo_t q;
		logic ovf;
		pt_carry_t pc;
	} div_st_t;

	// One result item.
	typedef struct packed {
		logic intersect_res;
		logic parallel;
		coord_t point_x, point_y, point_z;
	} out_item_t;

endpackage

// ===== rtl/sis_if.sv =====
// Handshake interfaces for the input and result channels.
// Depends on sis_pkg for the coordinate type.
interface sis_in_if import sis_pkg::*; ();
	logic valid, ready;
	coord_t a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z;
	coord_t b_start_x, b_start_y, b_end_x, b_end_y;
	modport source(output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
		a_end_z, b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink(input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
		a_end_z, b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
	logic valid, ready;
	logic intersect_res, parallel;
	coord_t point_x, point_y, point_z;
	modport source(output valid, intersect_res, parallel, point_x, point_y, point_z,
		input ready);
	modport sink(input valid, intersect_res, parallel, point_x, point_y, point_z,
		output ready);
endinterface

// ===== rtl/sis_front.sv =====
// Front end: differences, exact products, determinant and numerators, the
// hit test and the start of the division. Depends on sis_pkg.
module sis_front import sis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      v_in,
	input  in_item_t  item,
	output logic      v_out,
	output div_st_t   st_out
);
	diff_t ax_s1, ay_s1, az_s1, cy_s1, cx_s1, tx_s1, ty_s1;
	coord_t a1x_s1, a1y_s1, a1z_s1;
	prod_t p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	pt_carry_t pc_s2, pc_s3, pc_s4;
	det_t d_s3, nt_s3, nu_s3;
	mag_t dmag_s4, tmag_s4;
	logic [3:0] v_q;
	det_t dn, tn, un;
	logic [NW-1:0] num;
	logic [NW-QW-1:0] num_hi;
	logic ovf;

	// Valid bits of the four front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], v_in};
		end
	end
	assign v_out = v_q[3];

	// Stage 1: exact coordinate differences.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= DW'(item.a2x) - DW'(item.a1x);
			ay_s1  <= DW'(item.a2y) - DW'(item.a1y);
			az_s1  <= DW'(item.a2z) - DW'(item.a1z);
			cy_s1  <= DW'(item.b1y) - DW'(item.b2y);
			cx_s1  <= DW'(item.b1x) - DW'(item.b2x);
			tx_s1  <= DW'(item.b1x) - DW'(item.a1x);
			ty_s1  <= DW'(item.b1y) - DW'(item.a1y);
			a1x_s1 <= item.a1x;
			a1y_s1 <= item.a1y;
			a1z_s1 <= item.a1z;
		end
	end

	// Stage 2: the six products.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= PW'(ax_s1) * PW'(cy_s1);
			p1_s2 <= PW'(cx_s1) * PW'(ay_s1);
			p2_s2 <= PW'(tx_s1) * PW'(cy_s1);
			p3_s2 <= PW'(cx_s1) * PW'(ty_s1);
			p4_s2 <= PW'(ax_s1) * PW'(ty_s1);
			p5_s2 <= PW'(tx_s1) * PW'(ay_s1);
			pc_s2 <= '{a1x: a1x_s1, a1y: a1y_s1, a1z: a1z_s1, dx: ax_s1, dy: ay_s1,
				dz: az_s1, hit: 1'b0, par: 1'b0, neg: 1'b0};
		end
	end

	// Stage 3: determinant and numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= SW'(p0_s2) - SW'(p1_s2);
			nt_s3 <= SW'(p2_s2) - SW'(p3_s2);
			nu_s3 <= SW'(p4_s2) - SW'(p5_s2);
			pc_s3 <= pc_s2;
		end
	end

	// Signs normalized so that the determinant is non-negative.
	always_comb begin
		dn = d_s3[SW-1] ? -d_s3 : d_s3;
		tn = d_s3[SW-1] ? -nt_s3 : nt_s3;
		un = d_s3[SW-1] ? -nu_s3 : nu_s3;
	end

	// Stage 4: hit test, parallel flag, sign of t and magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			pc_s4 <= '{a1x: pc_s3.a1x, a1y: pc_s3.a1y, a1z: pc_s3.a1z,
				dx: pc_s3.dx, dy: pc_s3.dy, dz: pc_s3.dz,
				hit: !tn[SW-1] && (tn <= dn) && !un[SW-1] && (un <= dn),
				par: (d_s3 == '0),
				neg: nt_s3[SW-1] != d_s3[SW-1]};
			dmag_s4   <= mag_t'(dn);
			tmag_s4   <= nt_s3[SW-1] ? mag_t'(-nt_s3) : mag_t'(nt_s3);
		end
	end

	// Scaled numerator; a quotient that needs more than QW bits saturates.
	always_comb begin
		num    = {tmag_s4, {FB{1'b0}}};
		num_hi = num[NW-1:QW];
		ovf    = SW'(num_hi) >= dmag_s4;
	end

	// Stage 5: initial state of the divider chain.
	always_ff @(posedge clk) begin
		if (en) begin
			st_out.rem <= ovf ? '0 : mag_t'(num_hi);
			st_out.dvs <= dmag_s4;
			st_out.lo  <= num[QW-1:0];
			st_out.q   <= '0;
			st_out.ovf <= ovf;
			st_out.pc  <= pc_s4;
		end
	end
endmodule

// ===== rtl/sis_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on sis_pkg.
module sis_div_cell import sis_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    v_in,
	input  div_st_t st_in,
	output logic    v_out,
	output div_st_t st_out
);
	logic [SW:0] r2;
	logic [SW:0] diff;
	logic take;

	// Shift in the next numerator bit and try the subtraction.
	always_comb begin
		r2   = {st_in.rem, st_in.lo[QW-1]};
		diff = r2 - {1'b0, st_in.dvs};
		take = r2 >= {1'b0, st_in.dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out.rem <= take ? diff[SW-1:0] : r2[SW-1:0];
			st_out.dvs <= st_in.dvs;
			st_out.lo  <= {st_in.lo[QW-2:0], 1'b0};
			st_out.q   <= {st_in.q[QW-2:0], take};
			st_out.ovf <= st_in.ovf;
			st_out.pc  <= st_in.pc;
		end
	end
endmodule

// ===== rtl/sis_point.sv =====
// Back end: saturates t, multiplies it into the segment direction and adds
// the start point with saturation. Depends on sis_pkg.
module sis_point import sis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      v_in,
	input  div_st_t   st_in,
	output logic      v_out,
	output out_item_t res
);
	localparam logic [QW-1:0] LimPos = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] LimNeg = {1'b1, {(QW-1){1'b0}}};
	localparam int SMW = MW - FB + 1;

	logic [QW-1:0] lim, qs;
	coord_t t_s1;
	pt_carry_t pc_s1, pc_s2;
	logic signed [MW-1:0] mx_s2, my_s2, mz_s2;
	logic [2:0] v_q;

	function automatic coord_t sat_add(logic signed [MW-1:0] m, coord_t a);
		logic signed [SMW-1:0] s;
		s = SMW'(m >>> FB) + SMW'(a);
		if (s > $signed(SMW'(LimPos))) return coord_t'(LimPos);
		else if (s < -$signed(SMW'(LimNeg))) return coord_t'(LimNeg);
		else return s[CW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], v_in};
		end
	end
	assign v_out = v_q[2];

	// Stage 1: saturate the quotient and restore the sign of t.
	always_comb begin
		lim = st_in.pc.neg ? LimNeg : LimPos;
		qs  = (st_in.ovf || st_in.q > lim) ? lim : st_in.q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= st_in.pc.neg ? -coord_t'(qs) : coord_t'(qs);
			pc_s1 <= st_in.pc;
		end
	end

	// Stage 2: direction times t.
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= MW'(pc_s1.dx) * MW'(t_s1);
			my_s2 <= MW'(pc_s1.dy) * MW'(t_s1);
			mz_s2 <= MW'(pc_s1.dz) * MW'(t_s1);
			pc_s2 <= pc_s1;
		end
	end

	// Stage 3: add the start point; parallel segments give a zero point.
	always_ff @(posedge clk) begin
		if (en) begin
			res.parallel      <= pc_s2.par;
			res.intersect_res <= pc_s2.hit && !pc_s2.par;
			res.point_x       <= pc_s2.par ? '0 : sat_add(mx_s2, pc_s2.a1x);
			res.point_y       <= pc_s2.par ? '0 : sat_add(my_s2, pc_s2.a1y);
			res.point_z       <= pc_s2.par ? '0 : sat_add(mz_s2, pc_s2.a1z);
		end
	end
endmodule

// ===== rtl/segment_intersection_2d.sv =====
// Segment intersection top level: front end, chain of divider cells and
// point back end. Depends on sis_pkg, sis_if, sis_front, sis_div_cell and
// sis_point.
//
// The block takes one segment pair per clock while not halted and returns one
// result per pair, in order, through four front stages, one divider setup
// stage, one divider cell per quotient bit (32), and three point stages
// ending in the output register. The whole pipeline moves together; it halts
// only while a result sits in the output register and the sink does not take
// it, and input ready is low in exactly those cycles.
module segment_intersection_2d import sis_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sis_in_if.sink       in_ch,
	sis_out_if.source    out_ch
);
	logic en;
	in_item_t item;
	logic v_front;
	div_st_t st_front;
	logic [QW:0] v_chain;
	div_st_t st_chain [QW+1];
	out_item_t res;

	// Pipeline advances unless a result is held back.
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	assign item = '{a1x: in_ch.a_start_x, a1y: in_ch.a_start_y, a1z: in_ch.a_start_z,
		a2x: in_ch.a_end_x, a2y: in_ch.a_end_y, a2z: in_ch.a_end_z,
		b1x: in_ch.b_start_x, b1y: in_ch.b_start_y,
		b2x: in_ch.b_end_x, b2y: in_ch.b_end_y};

	sis_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_ch.valid && en),
		.item(item), .v_out(v_front), .st_out(st_front)
	);

	// The setup register's valid bit sits ahead of the chain.
	logic v_setup_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_setup_q <= 1'b0;
		end else if (en) begin
			v_setup_q <= v_front;
		end
	end

	assign v_chain[0]  = v_setup_q;
	assign st_chain[0] = st_front;

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < QW; i++) begin : g_cell
		sis_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(v_chain[i]), .st_in(st_chain[i]),
			.v_out(v_chain[i+1]), .st_out(st_chain[i+1])
		);
	end

	sis_point u_point (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_chain[QW]),
		.st_in(st_chain[QW]), .v_out(out_ch.valid), .res(res)
	);

	assign out_ch.intersect_res = res.intersect_res;
	assign out_ch.parallel      = res.parallel;
	assign out_ch.point_x       = res.point_x;
	assign out_ch.point_y       = res.point_y;
	assign out_ch.point_z       = res.point_z;
endmodule

// ===== rtl/sis_checker.sv =====
// Port-level checks for the segment intersection block, bound to the top.
// Depends on sis_pkg and segment_intersection_2d.
module sis_checker import sis_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input logic   intersect_res,
	input logic   parallel,
	input coord_t point_x,
	input coord_t point_y,
	input coord_t point_z
);
	// A held result keeps its point_x and parallel values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(parallel))
		else $error("result changed while stalled");

	// Parallel segments give no intersection and a zero point.
	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parallel |-> !intersect_res && point_x == '0 &&
		point_y == '0 && point_z == '0)
		else $error("parallel result with point or hit");

	// Input is taken whenever the output register is free or being emptied.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// Reset clears the result valid bit.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result right after reset");
endmodule

bind segment_intersection_2d sis_checker u_sis_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.intersect_res(out_ch.intersect_res), .parallel(out_ch.parallel),
	.point_x(out_ch.point_x), .point_y(out_ch.point_y), .point_z(out_ch.point_z)
);

// ===== test/tb_segment_intersection_2d.sv =====
// Testbench for segment_intersection_2d: directed segment pairs, then random ones,
// each result checked against a listed result or an exact fixed-point intersection predictor.
// Depends on sis_pkg, sis_in_if, sis_out_if and the segment_intersection_2d RTL.
module tb_segment_intersection_2d import sis_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1630;
	localparam int LATENCY = 40;
	localparam coord_t ONE = 32'sh0001_0000;
	localparam coord_t CMAX = 32'sh7fff_ffff;
	localparam coord_t CMIN = 32'sh8000_0000;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		in_item_t pair;
		bit known;
		out_item_t res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sis_in_if in_ch();
	sis_out_if out_ch();

	segment_intersection_2d dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	out_item_t expected_results[$];
	int errors = 0;
	bit quiet = 1'b0;
	bit cur_known = 1'b0;
	out_item_t cur_res;
	vec_t vectors[$];

	// Saturate an exact value to the coordinate range.
	function automatic coord_t sat_coord(wide_t v);
		if (v > wide_t'(CMAX)) begin
			return CMAX;
		end
		if (v < wide_t'(CMIN)) begin
			return CMIN;
		end
		return coord_t'(v);
	endfunction

	// Point on segment A for a given Q16.16 parameter t.
	function automatic coord_t interp(coord_t p1, coord_t p2, wide_t t);
		wide_t dp;
		wide_t p;
		dp = wide_t'(p2) - wide_t'(p1);
		p = ((dp * t) >>> FB) + wide_t'(p1);
		return sat_coord(p);
	endfunction

	// Exact intersection of the two segments, as the block should report it.
	function automatic out_item_t intersect_pair(in_item_t s);
		wide_t ax, ay, bx, by, cx, cy, d, nt, nu, dn, tn, un, t;
		logic [127:0] mag, lim;
		logic neg;
		out_item_t r;
		ax = wide_t'(s.a2x) - wide_t'(s.a1x);
		ay = wide_t'(s.a2y) - wide_t'(s.a1y);
		bx = wide_t'(s.b1x) - wide_t'(s.b2x);
		by = wide_t'(s.b1y) - wide_t'(s.b2y);
		cx = wide_t'(s.b1x) - wide_t'(s.a1x);
		cy = wide_t'(s.b1y) - wide_t'(s.a1y);
		d = ax * by - bx * ay;
		r = '0;
		if (d == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		nt = cx * by - bx * cy;
		nu = ax * cy - cx * ay;
		dn = d;
		tn = nt;
		un = nu;
		if (dn < 0) begin
			dn = -dn;
			tn = -tn;
			un = -un;
		end
		r.intersect_res = (tn >= 0) && (tn <= dn) && (un >= 0) && (un <= dn);
		neg = (nt < 0) != (d < 0);
		mag = ((nt < 0 ? -nt : nt) << FB) / (d < 0 ? -d : d);
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (mag > lim) begin
			mag = lim;
		end
		t = neg ? -wide_t'(mag) : wide_t'(mag);
		r.point_x = interp(s.a1x, s.a2x, t);
		r.point_y = interp(s.a1y, s.a2y, t);
		r.point_z = interp(s.a1z, s.a2z, t);
		return r;
	endfunction

	function automatic in_item_t seg(coord_t a1x, coord_t a1y, coord_t a1z, coord_t a2x,
			coord_t a2y, coord_t a2z, coord_t b1x, coord_t b1y, coord_t b2x, coord_t b2y);
		in_item_t s;
		s.a1x = a1x; s.a1y = a1y; s.a1z = a1z;
		s.a2x = a2x; s.a2y = a2y; s.a2z = a2z;
		s.b1x = b1x; s.b1y = b1y; s.b2x = b2x; s.b2y = b2y;
		return s;
	endfunction

	function automatic out_item_t res_of(logic hit, logic par, coord_t px, coord_t py,
			coord_t pz);
		out_item_t r;
		r.intersect_res = hit;
		r.parallel = par;
		r.point_x = px;
		r.point_y = py;
		r.point_z = pz;
		return r;
	endfunction

	function automatic void add_vec(in_item_t s, bit known, out_item_t r);
		vec_t v;
		v.pair = s;
		v.known = known;
		v.res = r;
		vectors.push_back(v);
	endfunction

	// A small coordinate within a few units of the origin.
	function automatic coord_t near_coord();
		return coord_t'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
	endfunction

	function automatic coord_t corner_coord();
		case ($urandom_range(0, 5))
			0: return CMIN;
			1: return CMAX;
			2: return '0;
			3: return -1;
			4: return 1;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Random pair: mostly small geometry that crosses often, plus full-range,
	// parallel, corner and shared-endpoint pairs.
	function automatic in_item_t random_pair();
		in_item_t s;
		int k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				s = seg(near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord(), near_coord(), near_coord());
			end
			5, 6: begin
				s = seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end
			7: begin
				s = seg(near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord(), '0, '0);
				k = int'($urandom_range(0, 4)) - 2;
				s.b2x = s.b1x + coord_t'(k) * (s.a2x - s.a1x);
				s.b2y = s.b1y + coord_t'(k) * (s.a2y - s.a1y);
			end
			8: begin
				s = seg(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
					corner_coord(), corner_coord(), corner_coord(), corner_coord(),
					corner_coord(), corner_coord());
			end
			default: begin
				s = seg(near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord(), near_coord(), near_coord());
				if ($urandom_range(0, 1)) begin
					s.b1x = s.a1x;
					s.b1y = s.a1y;
				end else begin
					s.b2x = s.a2x;
					s.b2y = s.a2y;
				end
			end
		endcase
		return s;
	endfunction

	// Offer one item, after an optional idle burst, and hold it until taken.
	task automatic send_pair(in_item_t s, bit known, out_item_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_ch.a_start_x = s.a1x; in_ch.a_start_y = s.a1y; in_ch.a_start_z = s.a1z;
		in_ch.a_end_x = s.a2x; in_ch.a_end_y = s.a2y; in_ch.a_end_z = s.a2z;
		in_ch.b_start_x = s.b1x; in_ch.b_start_y = s.b1y;
		in_ch.b_end_x = s.b2x; in_ch.b_end_y = s.b2y;
		cur_known = known;
		cur_res = r;
		in_ch.valid = 1'b1;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Record the expected result of each accepted item.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_results.push_back(cur_known ? cur_res : intersect_pair(seg(
				in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z, in_ch.a_end_x,
				in_ch.a_end_y, in_ch.a_end_z, in_ch.b_start_x, in_ch.b_start_y,
				in_ch.b_end_x, in_ch.b_end_y)));
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result hit=%0b par=%0b", $realtime,
					out_ch.intersect_res, out_ch.parallel);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_ch.intersect_res !== e.intersect_res) begin
					$display("%0t: intersect_res expected %0b got %0b", $realtime,
						e.intersect_res, out_ch.intersect_res);
					errors++;
				end
				if (out_ch.parallel !== e.parallel) begin
					$display("%0t: parallel expected %0b got %0b", $realtime,
						e.parallel, out_ch.parallel);
					errors++;
				end
				if (out_ch.point_x !== e.point_x) begin
					$display("%0t: point_x expected %h got %h", $realtime,
						e.point_x, out_ch.point_x);
					errors++;
				end
				if (out_ch.point_y !== e.point_y) begin
					$display("%0t: point_y expected %h got %h", $realtime,
						e.point_y, out_ch.point_y);
					errors++;
				end
				if (out_ch.point_z !== e.point_z) begin
					$display("%0t: point_z expected %h got %h", $realtime,
						e.point_z, out_ch.point_z);
					errors++;
				end
			end
		end
	end

	// Result side stalls in random bursts until the quiet tail of the run.
	always @(negedge clk) begin
		int hold;
		if (quiet) begin
			out_ch.ready = 1'b1;
		end else if (out_ch.ready && $urandom_range(0, 5) == 0) begin
			hold = $urandom_range(1, 7);
			out_ch.ready = 1'b0;
			repeat (hold) @(negedge clk);
			out_ch.ready = 1'b1;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Hard limit on the run time.
	initial begin
		#5ms;
		$display("[segment_intersection_2d] ERROR");
		$finish;
	end

	initial begin
		out_item_t none;
		int waited;
		none = '0;
		in_ch.valid = 1'b0;
		in_ch.a_start_x = '0; in_ch.a_start_y = '0; in_ch.a_start_z = '0;
		in_ch.a_end_x = '0; in_ch.a_end_y = '0; in_ch.a_end_z = '0;
		in_ch.b_start_x = '0; in_ch.b_start_y = '0; in_ch.b_end_x = '0; in_ch.b_end_y = '0;
		out_ch.ready = 1'b1;

		// Directed pairs: degenerate, crossing, endpoint touches and extremes.
		add_vec(seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res_of(0, 1, 0, 0, 0));
		add_vec(seg(0, 0, 0, 2 * ONE, 2 * ONE, 4 * ONE, 0, 2 * ONE, 2 * ONE, 0), 1,
			res_of(1, 0, ONE, ONE, 2 * ONE));
		add_vec(seg(0, 0, 0, 2 * ONE, 2 * ONE, 4 * ONE, 2 * ONE, 0, 0, 2 * ONE), 0, none);
		add_vec(seg(0, 0, ONE, 2 * ONE, 0, 0, 0, -ONE, 0, ONE), 0, none);
		add_vec(seg(0, 0, ONE, 2 * ONE, 0, 0, 2 * ONE, -ONE, 2 * ONE, ONE), 0, none);
		add_vec(seg(0, 0, ONE, 2 * ONE, 0, 0, 2 * ONE + 1, -ONE, 2 * ONE + 1, ONE),
			0, none);
		add_vec(seg(0, 0, 0, 3 * ONE, 0, 0, ONE, ONE, ONE, 2 * ONE), 0, none);
		add_vec(seg(0, 0, 0, ONE, ONE, ONE, ONE, 0, 2 * ONE, ONE), 1, res_of(0, 1, 0, 0, 0));
		add_vec(seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
			res_of(0, 1, 0, 0, 0));
		add_vec(seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1,
			res_of(0, 1, 0, 0, 0));
		add_vec(seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), 0, none);
		add_vec(seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN), 0, none);
		add_vec(seg(0, 0, 0, 1, 0, CMAX, CMAX, -ONE, CMAX, ONE), 0, none);
		add_vec(seg(0, 0, 0, 1, 0, CMIN, CMIN, -ONE, CMIN, ONE), 0, none);
		add_vec(seg(CMIN, 0, CMIN, CMIN + 1, 0, CMAX, CMAX, CMIN, CMAX, CMAX), 0, none);
		add_vec(seg(0, 0, 0, 4 * ONE, 0, 0, ONE, ONE, ONE, 2 * ONE), 0, none);
		add_vec(seg(-ONE, -ONE, -1, -ONE, ONE, 1, -2 * ONE, 0, 2 * ONE, 0), 0, none);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (vectors[i]) begin
			send_pair(vectors[i].pair, vectors[i].known, vectors[i].res);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Let the pipeline drain completely once, mid-run.
			if (n == N_RANDOM / 2) begin
				in_ch.valid = 1'b0;
				while (expected_results.size() != 0) @(negedge clk);
			end
			if (n == N_RANDOM - 200) begin
				quiet = 1'b1;
			end
			send_pair(random_pair(), 0, none);
		end
		in_ch.valid = 1'b0;

		waited = 0;
		while (expected_results.size() != 0 && waited < 10000) begin
			@(negedge clk);
			waited++;
		end
		repeat (LATENCY + 8) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("[segment_intersection_2d] OK");
		end else begin
			$display("[segment_intersection_2d] ERROR");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/sis_pkg.sv
rtl/sis_if.sv
rtl/sis_front.sv
rtl/sis_div_cell.sv
rtl/sis_point.sv
rtl/segment_intersection_2d.sv
rtl/sis_checker.sv
test/tb_segment_intersection_2d.sv
